/* hw/rtl/char_lcd_write_sequencer_macros.svh */
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLWS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("char_lcd_write_sequencer: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CLWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("char_lcd_write_sequencer: assertion failed");

`endif

/* hw/rtl/clws_pkg.sv */
`timescale 1ns / 1ps

package clws_pkg;

	// Request codes on the cmd port.
	localparam logic [1:0] CMD_WR_CMD  = 2'd0;
	localparam logic [1:0] CMD_WR_DATA = 2'd1;
	localparam logic [1:0] CMD_PRINT   = 2'd2;
	localparam logic [1:0] CMD_INIT    = 2'd3;

	localparam int DIGITS_MAX = 10;

	localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;
	localparam int          RECIP_SHR = 35;

	localparam logic [7:0]  ASCII_ZERO  = 8'h30;
	localparam logic [7:0]  ASCII_MINUS = 8'h2D;

	localparam logic [13:0] WAIT_NONE        = 14'd0;
	localparam logic [13:0] WAIT_POWER_UP    = 14'd15000;
	localparam logic [12:0] SETTLE_NORMAL    = 13'd2000;
	localparam logic [12:0] SETTLE_INIT_1ST  = 13'd7000;
	localparam logic [12:0] SETTLE_INIT_2ND  = 13'd2100;

	typedef logic [3:0] upc_t;
	typedef logic [3:0] dcnt_t;

	// Microprogram entry points and loop targets.
	localparam upc_t UPC_CMD   = 4'd0;
	localparam upc_t UPC_DATA  = 4'd1;
	localparam upc_t UPC_INIT  = 4'd2;
	localparam upc_t UPC_PRINT = 4'd9;
	localparam upc_t UPC_MUL   = 4'd10;
	localparam upc_t UPC_DIV   = 4'd11;
	localparam upc_t UPC_POP   = 4'd12;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_ALWAYS,
		EMIT_IF_NEG
	} emit_t;

	typedef enum logic [1:0] {
		BSRC_VALUE,
		BSRC_CONST,
		BSRC_DIGIT
	} bsrc_t;

	typedef enum logic [1:0] {
		LAST_NO,
		LAST_YES,
		LAST_IF_FINAL
	} last_t;

	typedef enum logic [1:0] {
		DP_NONE,
		DP_MUL,
		DP_DIV,
		DP_POP
	} dpop_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_DONE,
		JMP_IF_QNZ,
		JMP_IF_MORE
	} jmp_t;

	typedef struct packed {
		emit_t       emit;
		bsrc_t       bsrc;
		logic        rs;
		logic [7:0]  byte_k;
		logic [13:0] wait_k;
		logic [12:0] settle_k;
		last_t       last;
		dpop_t       dp;
		jmp_t        jmp;
		upc_t        target;
	} ucode_t;

	// Datapath flags that steer the conditional jumps.
	typedef struct packed {
		logic neg;
		logic q_nz;
		logic more;
	} dp_status_t;

	function automatic ucode_t uw(emit_t emit, bsrc_t bsrc, logic rs, logic [7:0] byte_k,
			logic [13:0] wait_k, logic [12:0] settle_k, last_t last, dpop_t dp,
			jmp_t jmp, upc_t target);
		ucode_t w;
		w.emit     = emit;
		w.bsrc     = bsrc;
		w.rs       = rs;
		w.byte_k   = byte_k;
		w.wait_k   = wait_k;
		w.settle_k = settle_k;
		w.last     = last;
		w.dp       = dp;
		w.jmp      = jmp;
		w.target   = target;
		return w;
	endfunction

	localparam ucode_t UW_NOP = '{EMIT_NONE, BSRC_CONST, 1'b0, 8'h00, WAIT_NONE,
		SETTLE_NORMAL, LAST_NO, DP_NONE, JMP_DONE, UPC_CMD};

	// Control store.
	function automatic ucode_t ucode_rom(upc_t pc);
		ucode_t w;
		case (pc)
			UPC_CMD: w = uw(EMIT_ALWAYS, BSRC_VALUE, 1'b0, 8'h00, WAIT_NONE,
				SETTLE_NORMAL, LAST_YES, DP_NONE, JMP_DONE, UPC_CMD);
			UPC_DATA: w = uw(EMIT_ALWAYS, BSRC_VALUE, 1'b1, 8'h00, WAIT_NONE,
				SETTLE_NORMAL, LAST_YES, DP_NONE, JMP_DONE, UPC_CMD);
			4'd2: w = uw(EMIT_ALWAYS, BSRC_CONST, 1'b0, 8'h30, WAIT_POWER_UP,
				SETTLE_INIT_1ST, LAST_NO, DP_NONE, JMP_NEXT, UPC_CMD);
			4'd3: w = uw(EMIT_ALWAYS, BSRC_CONST, 1'b0, 8'h30, WAIT_NONE,
				SETTLE_INIT_2ND, LAST_NO, DP_NONE, JMP_NEXT, UPC_CMD);
			4'd4: w = uw(EMIT_ALWAYS, BSRC_CONST, 1'b0, 8'h30, WAIT_NONE,
				SETTLE_NORMAL, LAST_NO, DP_NONE, JMP_NEXT, UPC_CMD);
			4'd5: w = uw(EMIT_ALWAYS, BSRC_CONST, 1'b0, 8'h38, WAIT_NONE,
				SETTLE_NORMAL, LAST_NO, DP_NONE, JMP_NEXT, UPC_CMD);
			4'd6: w = uw(EMIT_ALWAYS, BSRC_CONST, 1'b0, 8'h0E, WAIT_NONE,
				SETTLE_NORMAL, LAST_NO, DP_NONE, JMP_NEXT, UPC_CMD);
			4'd7: w = uw(EMIT_ALWAYS, BSRC_CONST, 1'b0, 8'h06, WAIT_NONE,
				SETTLE_NORMAL, LAST_NO, DP_NONE, JMP_NEXT, UPC_CMD);
			4'd8: w = uw(EMIT_ALWAYS, BSRC_CONST, 1'b0, 8'h01, WAIT_NONE,
				SETTLE_NORMAL, LAST_YES, DP_NONE, JMP_DONE, UPC_CMD);
			UPC_PRINT: w = uw(EMIT_IF_NEG, BSRC_CONST, 1'b1, ASCII_MINUS, WAIT_NONE,
				SETTLE_NORMAL, LAST_NO, DP_NONE, JMP_NEXT, UPC_CMD);
			UPC_MUL: w = uw(EMIT_NONE, BSRC_CONST, 1'b1, 8'h00, WAIT_NONE,
				SETTLE_NORMAL, LAST_NO, DP_MUL, JMP_NEXT, UPC_CMD);
			UPC_DIV: w = uw(EMIT_NONE, BSRC_CONST, 1'b1, 8'h00, WAIT_NONE,
				SETTLE_NORMAL, LAST_NO, DP_DIV, JMP_IF_QNZ, UPC_MUL);
			UPC_POP: w = uw(EMIT_ALWAYS, BSRC_DIGIT, 1'b1, 8'h00, WAIT_NONE,
				SETTLE_NORMAL, LAST_IF_FINAL, DP_POP, JMP_IF_MORE, UPC_POP);
			default: w = UW_NOP;
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/clws_seq.sv */
`timescale 1ns / 1ps

module clws_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            cmd,
	input  clws_pkg::dp_status_t  status,
	output logic                  busy,
	output clws_pkg::ucode_t      uword
);

	clws_pkg::upc_t   pc_q;
	logic             busy_q;
	clws_pkg::upc_t   entry;
	clws_pkg::upc_t   pc_next;
	logic             busy_next;
	clws_pkg::ucode_t rom_word;

	always_comb begin
		case (cmd)
			clws_pkg::CMD_WR_CMD:  entry = clws_pkg::UPC_CMD;
			clws_pkg::CMD_WR_DATA: entry = clws_pkg::UPC_DATA;
			clws_pkg::CMD_PRINT:   entry = clws_pkg::UPC_PRINT;
			clws_pkg::CMD_INIT:    entry = clws_pkg::UPC_INIT;
			default:               entry = clws_pkg::UPC_CMD;
		endcase
	end

	assign rom_word = clws_pkg::ucode_rom(pc_q);
	assign uword    = busy_q ? rom_word : clws_pkg::UW_NOP;
	assign busy     = busy_q;

	always_comb begin
		pc_next   = pc_q;
		busy_next = busy_q;
		if (accept) begin
			pc_next   = entry;
			busy_next = 1'b1;
		end else if (busy_q) begin
			case (rom_word.jmp)
				clws_pkg::JMP_NEXT: pc_next = pc_q + 4'd1;
				clws_pkg::JMP_DONE: busy_next = 1'b0;
				clws_pkg::JMP_IF_QNZ: begin
					if (status.q_nz) pc_next = rom_word.target;
					else pc_next = pc_q + 4'd1;
				end
				clws_pkg::JMP_IF_MORE: begin
					if (status.more) pc_next = rom_word.target;
					else busy_next = 1'b0;
				end
				default: busy_next = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= clws_pkg::UPC_CMD;
			busy_q <= 1'b0;
		end else begin
			pc_q   <= pc_next;
			busy_q <= busy_next;
		end
	end

endmodule

/* hw/rtl/clws_datapath.sv */
`timescale 1ns / 1ps

module clws_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic signed [31:0]    value,
	input  clws_pkg::ucode_t      uword,
	output clws_pkg::dp_status_t  status,
	output logic                  strobe,
	output logic                  rs,
	output logic [7:0]            bus_byte,
	output logic [13:0]           wait_before_us,
	output logic [12:0]           settle_us,
	output logic                  last
);

	logic [31:0]           mag_q;
	logic                  neg_q;
	logic [7:0]            byte_q;
	logic [63:0]           prod_q;
	logic [3:0]            stk_q [clws_pkg::DIGITS_MAX];
	clws_pkg::dcnt_t       cnt_q;
	logic                  strobe_q;
	logic                  rs_q;
	logic [7:0]            bus_byte_q;
	logic [13:0]           wait_q;
	logic [12:0]           settle_q;
	logic                  last_q;

	logic [31:0]           quot;
	logic [31:0]           quot_x10;
	logic [31:0]           rem_full;
	logic                  do_emit;
	logic [7:0]            emit_byte;
	logic                  emit_last;

	// Quotient by ten from the registered reciprocal product; the remainder is the digit.
	assign quot     = {3'b000, prod_q[63:clws_pkg::RECIP_SHR]};
	assign quot_x10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
	assign rem_full = mag_q - quot_x10;

	assign status.neg  = neg_q;
	assign status.q_nz = (quot != 32'd0);
	assign status.more = (cnt_q != 4'd1);

	always_comb begin
		case (uword.emit)
			clws_pkg::EMIT_ALWAYS: do_emit = 1'b1;
			clws_pkg::EMIT_IF_NEG: do_emit = neg_q;
			default:               do_emit = 1'b0;
		endcase
		case (uword.bsrc)
			clws_pkg::BSRC_VALUE: emit_byte = byte_q;
			clws_pkg::BSRC_DIGIT: emit_byte = clws_pkg::ASCII_ZERO + {4'b0000, stk_q[0]};
			default:              emit_byte = uword.byte_k;
		endcase
		case (uword.last)
			clws_pkg::LAST_YES:      emit_last = 1'b1;
			clws_pkg::LAST_IF_FINAL: emit_last = (cnt_q == 4'd1);
			default:                 emit_last = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= do_emit;
			case (uword.dp)
				clws_pkg::DP_DIV: cnt_q <= cnt_q + 4'd1;
				clws_pkg::DP_POP: cnt_q <= cnt_q - 4'd1;
				default:          cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q  <= value[31];
			mag_q  <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
			byte_q <= value[7:0];
		end else begin
			case (uword.dp)
				clws_pkg::DP_MUL: prod_q <= {32'd0, mag_q} * {32'd0, clws_pkg::RECIP_10};
				clws_pkg::DP_DIV: begin
					mag_q    <= quot;
					stk_q[0] <= rem_full[3:0];
					for (int i = 1; i < clws_pkg::DIGITS_MAX; i++) stk_q[i] <= stk_q[i-1];
				end
				clws_pkg::DP_POP: begin
					for (int i = 0; i < clws_pkg::DIGITS_MAX - 1; i++) stk_q[i] <= stk_q[i+1];
				end
				default: ;
			endcase
		end
		if (do_emit) begin
			rs_q       <= uword.rs;
			bus_byte_q <= emit_byte;
			wait_q     <= uword.wait_k;
			settle_q   <= uword.settle_k;
			last_q     <= emit_last;
		end
	end

	assign strobe         = strobe_q;
	assign rs             = rs_q;
	assign bus_byte       = bus_byte_q;
	assign wait_before_us = wait_q;
	assign settle_us      = settle_q;
	assign last           = last_q;

endmodule

/* hw/rtl/char_lcd_write_sequencer.sv */
`timescale 1ns / 1ps
// A taken start is registered in the sequencer's pc and busy registers, and each write in the
// datapath's output registers. A byte write, init or negative print strobes its first write
// from its first microcode step; a non-negative print first runs the divide-by-ten loop over
// all digits. One microcode step runs per cycle; a print stays busy longer with more digits,
// and start is taken whenever busy is low. Results come one per strobe and cannot be stalled.
// Reset (arst_n low) returns the sequencer to idle with no strobe pending.
module char_lcd_write_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] value,
	output logic               strobe,
	output logic               rs,
	output logic [7:0]         bus_byte,
	output logic [13:0]        wait_before_us,
	output logic [12:0]        settle_us,
	output logic               last
);

	logic                 accept;
	clws_pkg::ucode_t     uword;
	clws_pkg::dp_status_t status;

	assign accept = start && !busy;

	clws_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.status (status),
		.busy   (busy),
		.uword  (uword)
	);

	clws_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (accept),
		.value          (value),
		.uword          (uword),
		.status         (status),
		.strobe         (strobe),
		.rs             (rs),
		.bus_byte       (bus_byte),
		.wait_before_us (wait_before_us),
		.settle_us      (settle_us),
		.last           (last)
	);

endmodule

/* hw/rtl/clws_checker.sv */
`timescale 1ns / 1ps
`include "char_lcd_write_sequencer_macros.svh"

module clws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic        rs,
	input logic [7:0]  bus_byte,
	input logic [13:0] wait_before_us,
	input logic [12:0] settle_us,
	input logic        last
);

	// A taken transaction keeps the sequencer busy on the following cycle.
	`CLWS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)

	// The final write of a transaction is shown only after the sequencer has gone idle.
	`CLWS_ASSERT_IMPL(a_last_idle, clk, arst_n, strobe && last, !busy)

	// Any write that is not the final one leaves the sequencer still working.
	`CLWS_ASSERT_IMPL(a_mid_busy, clk, arst_n, strobe && !last, busy)

	// Only the first power-up write carries a wait before it.
	`CLWS_ASSERT_IMPL(a_power_up_wait, clk, arst_n, strobe && (wait_before_us != 14'd0),
		!rs && (bus_byte == 8'h30) && (settle_us == 13'd7000))

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.strobe         (strobe),
	.rs             (rs),
	.bus_byte       (bus_byte),
	.wait_before_us (wait_before_us),
	.settle_us      (settle_us),
	.last           (last)
);
